// ----- src/mpbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpbm_pkg;

  // Field widths of the request and result items.
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 3;
  localparam int CIDX_W  = 5;
  localparam int CHAR_W  = 8;
  localparam int MASK_W  = 8;
  localparam int DSLOT_W = 3;

  // A pattern length is at most char_index + 1, so it fits in six bits.
  localparam int POS_W = 6;

  // Configuration port.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERMANENT = 1'd1;

  localparam int DEF_SLOTS       = 8;
  localparam int DEF_PATTERN_LEN = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_DATA    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [CIDX_W-1:0] char_index;
    logic [CHAR_W-1:0] char_value;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]  match_mask;
    logic               permanent_hit;
    logic               dynamic_hit;
    logic [DSLOT_W-1:0] dynamic_slot;
  } result_t;

  // What one cell hands to its right neighbor: the request and the partial result.
  typedef struct packed {
    item_t   item;
    result_t res;
  } link_t;

  // Settings every cell sees; act_slots is already clamped to the slot count.
  typedef struct packed {
    logic [CFG_W-1:0] act_slots;
    logic [CFG_W-1:0] perm_slots;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/mpbm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/mpbm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpbm_cell #(
  parameter int K           = 0,
  parameter int PATTERN_LEN = mpbm_pkg::DEF_PATTERN_LEN
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mpbm_pkg::cfg_t  cfg,
  input  wire logic            left_valid,
  output logic                 left_ready,
  input  wire mpbm_pkg::link_t left_link,
  output logic                 right_valid,
  input  wire logic            right_ready,
  output mpbm_pkg::link_t      right_link
);

  import mpbm_pkg::*;

  localparam int AW = $clog2(PATTERN_LEN);

  logic              vld;
  link_t             link;
  logic [POS_W-1:0]  len;
  logic [POS_W-1:0]  pos;
  logic              byp;
  logic [CHAR_W-1:0] byp_data;

  logic              take;
  logic [POS_W-1:0]  len_next;
  logic [POS_W-1:0]  pos_next;
  result_t           res_next;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] expected;

  assign left_ready  = !vld || right_ready;
  assign take        = left_valid && left_ready;
  assign right_valid = vld;
  assign right_link  = link;

  assign waddr    = AW'(left_link.item.char_index);
  assign expected = byp ? byp_data : rdata;

  always_comb begin
    logic addressed;
    logic [POS_W-1:0] pos_inc;
    addressed = (32'(left_link.item.slot) == K);
    pos_inc   = pos + POS_W'(1);
    len_next  = len;
    pos_next  = pos;
    res_next  = left_link.res;
    we        = 1'b0;
    if (take) begin
      unique case (cmd_e'(left_link.item.cmd))
        CMD_LOAD: begin
          if (addressed && (32'(left_link.item.char_index) < PATTERN_LEN)) begin
            we       = 1'b1;
            pos_next = '0;
            if (left_link.item.last_char) begin
              len_next = POS_W'(left_link.item.char_index) + POS_W'(1);
            end
          end
        end
        CMD_RESTART: begin
          if (addressed) begin
            pos_next = '0;
          end
        end
        CMD_DATA: begin
          if (K < 32'(cfg.act_slots)) begin
            if ((pos >= len) || (left_link.item.char_value != expected)) begin
              pos_next = '0;
            end else begin
              pos_next = pos_inc;
              if (pos_inc == len) begin
                res_next.match_mask = left_link.res.match_mask | (MASK_W'(1) << K);
                if (K < 32'(cfg.perm_slots)) begin
                  res_next.permanent_hit = 1'b1;
                end else begin
                  res_next.dynamic_hit  = 1'b1;
                  res_next.dynamic_slot = DSLOT_W'(K);
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The character at the next position is read ahead from the registered RAM.
  assign raddr = rst ? '0 : AW'(pos_next);

  mpbm_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(PATTERN_LEN)
  ) u_chars (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(left_link.item.char_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      len <= '0;
      pos <= '0;
      byp <= 1'b0;
    end else begin
      if (left_ready) begin
        vld <= left_valid;
      end
      len <= len_next;
      pos <= pos_next;
      byp <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      link.item <= left_link.item;
      link.res  <= res_next;
    end
    byp_data <= left_link.item.char_value;
  end

endmodule

`default_nettype wire

// ----- src/multi_pattern_byte_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  mpbm_pkg::item_t (data, load, restart)
// result    out        result_valid/stall     mpbm_pkg::result_t (one per data byte)
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// One request is taken per cycle while no result stall backs up the row. A data
// byte's result shows once it has passed the register in every slot cell.
// Reset clears all positions and lengths and both registers; pattern characters
// are not cleared. A stall on the result channel propagates back through the
// row only as far as there are no empty stages to absorb it.

module multi_pattern_byte_matcher #(
  parameter int SLOTS       = mpbm_pkg::DEF_SLOTS,
  parameter int PATTERN_LEN = mpbm_pkg::DEF_PATTERN_LEN
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire mpbm_pkg::item_t              item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output mpbm_pkg::result_t                 result,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mpbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mpbm_pkg::CFG_W-1:0]   cfg_data
);

  import mpbm_pkg::*;

  logic [CFG_W-1:0] active_slots;
  logic [CFG_W-1:0] permanent_slots;
  cfg_t             cfg;

  // Link k feeds cell k; the last link is the output register of the last cell.
  logic  chain_valid [SLOTS+1];
  logic  chain_ready [SLOTS+1];
  link_t chain_link  [SLOTS+1];
  logic  last_is_data;

  // The register port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots    <= '0;
      permanent_slots <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE:    active_slots    <= cfg_data;
        REG_PERMANENT: permanent_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  // A slot counts as permanent only when it is also active, so clamping the
  // permanent count to the active count falls out of the per-cell test.
  assign cfg.act_slots  = (32'(active_slots) > SLOTS) ? CFG_W'(SLOTS) : active_slots;
  assign cfg.perm_slots = permanent_slots;

  // Each request enters with an empty partial result.
  assign chain_valid[0]    = item_valid;
  assign chain_link[0].item = item;
  assign chain_link[0].res  = '0;
  assign item_stall         = !chain_ready[0];

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    mpbm_cell #(
      .K          (k),
      .PATTERN_LEN(PATTERN_LEN)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg        (cfg),
      .left_valid (chain_valid[k]),
      .left_ready (chain_ready[k]),
      .left_link  (chain_link[k]),
      .right_valid(chain_valid[k+1]),
      .right_ready(chain_ready[k+1]),
      .right_link (chain_link[k+1])
    );
  end

  // Load, restart and unknown requests leave the row without a result.
  assign last_is_data       = (cmd_e'(chain_link[SLOTS].item.cmd) == CMD_DATA);
  assign result_valid       = chain_valid[SLOTS] && last_is_data;
  assign result             = chain_link[SLOTS].res;
  assign chain_ready[SLOTS] = !result_stall || !last_is_data;

  // The slot number reported for dynamic hits is zero when there was none.
  a_dslot_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.dynamic_hit |-> result.dynamic_slot == '0)
    else $error("dynamic_slot set without a dynamic hit");

  // Only slots below the active count can report a match.
  a_mask_active: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.match_mask >> cfg.act_slots) == '0)
    else $error("match reported for an inactive slot");

  // With every slot visible in the mask, a hit flag needs a mask bit.
  a_hit_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid && (SLOTS <= MASK_W) && (result.match_mask == '0)
      |-> !result.permanent_hit && !result.dynamic_hit)
    else $error("hit flag without any match_mask bit");

  // The input is held off only by a pending, stalled result at the end of the row.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled while the output side is free");

endmodule

`default_nettype wire

// ----- dv/tb_multi_pattern_byte_matcher.sv -----
`timescale 1ns / 1ps

module tb_multi_pattern_byte_matcher;

  import mpbm_pkg::*;

  localparam int SLOTS = DEF_SLOTS;
  localparam int PLEN  = DEF_PATTERN_LEN;

  // Loads and restarts give no result, so after the last result has arrived we
  // let any still in the row of slot cells run out before touching a register.
  localparam int DRAIN_CYCLES = 2 * SLOTS + 4;
  localparam int WAIT_LIMIT   = 20000;
  localparam int PRINT_LIMIT  = 200;

  localparam int ITEM_W = $bits(item_t);

  // The one command code the block has no meaning for.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  multi_pattern_byte_matcher #(
    .SLOTS      (SLOTS),
    .PATTERN_LEN(PLEN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the matcher: pattern store, lengths, positions and the
  // two registers, all updated when the block accepts the request.
  logic [7:0]       pred_char   [SLOTS][PLEN];
  bit               char_loaded [SLOTS][PLEN];
  int unsigned      pred_len    [SLOTS];
  int unsigned      pred_pos    [SLOTS];
  logic [CFG_W-1:0] pred_active = '0;
  logic [CFG_W-1:0] pred_perm   = '0;

  // Results still owed by the block, one per data byte, oldest first.
  result_t expected_hits[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned hits_seen      = 0;
  int unsigned reg_writes     = 0;

  initial begin
    foreach (pred_len[s]) begin
      pred_len[s] = 0;
      pred_pos[s] = 0;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    // Only the first few hundred are printed; all of them are counted.
    if (errors <= PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Applies one accepted request to the shadow state. A data byte walks every
  // compared slot: a slot that already sits at its full length, or whose
  // expected character differs, drops back to position 0 without testing the
  // byte again as a first character. A slot that reaches its length reports.
  task automatic advance_matcher(input item_t req);
    int unsigned act;
    int unsigned perm;
    int unsigned p;
    result_t     hit;
    begin
      case (req.cmd)
        CMD_LOAD: begin
          pred_char[req.slot][req.char_index]   = req.char_value;
          char_loaded[req.slot][req.char_index] = 1'b1;
          if (req.last_char) pred_len[req.slot] = req.char_index + 1;
          pred_pos[req.slot] = 0;
        end
        CMD_RESTART: begin
          pred_pos[req.slot] = 0;
        end
        CMD_DATA: begin
          // Both registers saturate: active at the slot count, permanent at
          // the active count.
          act  = (pred_active > SLOTS) ? SLOTS : pred_active;
          perm = (pred_perm > act) ? act : pred_perm;
          hit  = '0;
          for (int i = 0; i < act; i++) begin
            p = pred_pos[i];
            if (p >= pred_len[i] || req.char_value != pred_char[i][p]) begin
              pred_pos[i] = 0;
            end else begin
              p++;
              pred_pos[i] = p;
              if (p == pred_len[i]) begin
                hit.match_mask[i] = 1'b1;
                if (i < perm) begin
                  hit.permanent_hit = 1'b1;
                end else begin
                  hit.dynamic_hit  = 1'b1;
                  hit.dynamic_slot = DSLOT_W'(i);
                end
              end
            end
          end
          expected_hits.push_back(hit);
        end
        default: ;
      endcase
    end
  endtask

  // Offers one request, idling beforehand at the current rate. Valid is left
  // high after acceptance so that the next request can follow back to back.
  task automatic send_request(input item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    advance_matcher(req);
    if (req.cmd != CMD_UNKNOWN) requests_sent++;
  endtask

  task automatic send_data(input logic [7:0] value);
    item_t req;
    req            = '0;
    req.cmd        = CMD_DATA;
    req.char_value = value;
    req.slot       = SLOT_W'($urandom_range(SLOTS - 1));
    req.char_index = CIDX_W'($urandom_range(PLEN - 1));
    req.last_char  = 1'($urandom_range(1));
    send_request(req);
  endtask

  task automatic load_char(input int unsigned s, input int unsigned idx,
                           input logic [7:0] value, input bit last);
    item_t req;
    req            = '0;
    req.cmd        = CMD_LOAD;
    req.slot       = SLOT_W'(s);
    req.char_index = CIDX_W'(idx);
    req.char_value = value;
    req.last_char  = last;
    send_request(req);
  endtask

  task automatic restart_slot(input int unsigned s);
    item_t req;
    req            = ITEM_W'($urandom);
    req.cmd        = CMD_RESTART;
    req.slot       = SLOT_W'(s);
    send_request(req);
  endtask

  // Stops offering requests and waits until every owed result has been seen,
  // then lets loads and restarts still in the row run out.
  task automatic drain_matcher();
    int n;
    item_valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < WAIT_LIMIT && expected_hits.size() != 0; n++) @(posedge clk);
    if (expected_hits.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_hits.size()));
      expected_hits.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers change only while the row is empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain_matcher();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ACTIVE) pred_active = value;
    else pred_perm = value;
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register values lean on the edges: empty, one slot, all slots, and the
  // values past the slot count that the block has to saturate.
  function automatic logic [CFG_W-1:0] pick_reg_value();
    case ($urandom_range(7))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd7;
      3:       return 4'd8;
      4:       return 4'd9;
      5:       return 4'd15;
      default: return CFG_W'($urandom_range(15));
    endcase
  endfunction

  // Mostly a narrow alphabet around a base so that patterns share characters
  // and partial matches overlap; now and then any byte at all.
  function automatic logic [7:0] pick_char(input logic [7:0] base);
    if ($urandom_range(4) != 0) return base + 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // Loads a whole pattern in order, with the length set by the final
  // character, so that every character a compare can reach has been written.
  task automatic program_slot(input int unsigned s, input int unsigned len,
                              input logic [7:0] base);
    for (int k = 0; k < len; k++) load_char(s, k, pick_char(base), k == len - 1);
  endtask

  // Feeds a slot's own pattern back as data. Sometimes the first character
  // is doubled, which must not restart the match, and now and then a byte is
  // spoiled so the slot falls back to position 0 partway through.
  task automatic stream_pattern(input int unsigned s, input logic [7:0] base);
    int unsigned len;
    logic [7:0]  b;
    len = pred_len[s];
    if ($urandom_range(3) == 0) send_data(pred_char[s][0]);
    for (int k = 0; k < len; k++) begin
      b = pred_char[s][k];
      if ($urandom_range(9) == 0) b = pick_char(base);
      send_data(b);
    end
  endtask

  // The receiver stalls at random and checks every result it takes against
  // the oldest owed one.
  always @(posedge clk) begin
    result_t want;
    result_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result.match_mask != 0) hits_seen++;
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none owed", result));
      end else begin
        want = expected_hits.pop_front();
        if (result.match_mask !== want.match_mask)
          report_mismatch($sformatf("match_mask %h, expected %h",
                                    result.match_mask, want.match_mask));
        if (result.permanent_hit !== want.permanent_hit)
          report_mismatch($sformatf("permanent_hit %b, expected %b",
                                    result.permanent_hit, want.permanent_hit));
        if (result.dynamic_hit !== want.dynamic_hit)
          report_mismatch($sformatf("dynamic_hit %b, expected %b",
                                    result.dynamic_hit, want.dynamic_hit));
        if (result.dynamic_slot !== want.dynamic_slot)
          report_mismatch($sformatf("dynamic_slot %0d, expected %0d",
                                    result.dynamic_slot, want.dynamic_slot));
      end
    end
  end

  // Straight out of reset no slot is compared, so data bytes report nothing,
  // and an unknown command produces no result at all.
  task automatic test_idle_matcher();
    item_t req;
    send_data(8'h00);
    send_data(8'hFF);
    req     = ITEM_W'($urandom);
    req.cmd = CMD_UNKNOWN;
    send_request(req);
  endtask

  // A one-character permanent pattern in slot 0 and a two-character dynamic
  // one in slot 7. The byte right after a full match only re-arms the slot,
  // so three equal bytes give hit, nothing, hit. Slot 5 gets a character at
  // the top index but no length, and must stay silent.
  task automatic test_match_and_rearm();
    write_reg(REG_ACTIVE, 4'd8);
    write_reg(REG_PERMANENT, 4'd1);
    load_char(0, 0, 8'h41, 1'b1);
    load_char(7, 0, 8'hFF, 1'b0);
    load_char(7, 1, 8'h00, 1'b1);
    load_char(5, PLEN - 1, 8'hAA, 1'b0);
    send_data(8'h41);
    send_data(8'h41);
    send_data(8'h41);
    send_data(8'hFF);
    send_data(8'h00);
  endtask

  // A restart, and a load into the slot mid-match, both throw away the
  // progress, so the closing byte alone does not complete the pattern.
  task automatic test_restart_and_reload();
    send_data(8'hFF);
    restart_slot(7);
    send_data(8'h00);
    send_data(8'hFF);
    load_char(7, 1, 8'h00, 1'b1);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h00);
  endtask

  // Oversized registers saturate: with both at their maximum every slot is
  // compared and every slot is permanent. With no permanent slots, slot 0
  // reports as the dynamic slot 0.
  task automatic test_register_clamp();
    write_reg(REG_ACTIVE, 4'd15);
    write_reg(REG_PERMANENT, 4'd15);
    send_data(8'h41);
    send_data(8'hFF);
    send_data(8'h00);
    write_reg(REG_ACTIVE, 4'd8);
    write_reg(REG_PERMANENT, 4'd0);
    send_data(8'h41);
  endtask

  // Rounds of traffic under one register setting each. Most of a round is
  // slots being fed their own patterns; the rest reprograms slots, restarts
  // them, scatters single loads and random bytes, and slips in unknown
  // commands.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned budget);
    int unsigned start;
    int unsigned act;
    int unsigned s;
    int unsigned k;
    int unsigned len;
    int unsigned sel;
    bit          last;
    logic [7:0]  base;
    item_t       req;
    begin
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start          = requests_sent;
      while (requests_sent - start < budget) begin
        write_reg(REG_ACTIVE, pick_reg_value());
        write_reg(REG_PERMANENT, pick_reg_value());
        act  = (pred_active > SLOTS) ? SLOTS : pred_active;
        base = 8'($urandom_range(255));
        repeat (30) begin
          sel = $urandom_range(99);
          // Streams go to compared slots; otherwise any slot will do.
          s   = (act != 0) ? $urandom_range(act - 1) : $urandom_range(SLOTS - 1);
          if (sel < 55) begin
            if (pred_len[s] != 0) stream_pattern(s, base);
            else program_slot(s, $urandom_range(4, 1), base);
          end else if (sel < 70) begin
            // Short patterns keep rounds quick; a few are longer, up to the full length.
            len = ($urandom_range(15) == 0) ? $urandom_range(PLEN, 6) : $urandom_range(5, 1);
            program_slot(s, len, base);
          end else if (sel < 78) begin
            restart_slot($urandom_range(SLOTS - 1));
          end else if (sel < 86) begin
            // A stray load anywhere; it may only set a length when every
            // character below it has been written.
            s    = $urandom_range(SLOTS - 1);
            k    = $urandom_range(PLEN - 1);
            last = 1'($urandom_range(1));
            for (int j = 0; j < k; j++) if (!char_loaded[s][j]) last = 1'b0;
            load_char(s, k, 8'($urandom_range(255)), last);
          end else if (sel < 96) begin
            send_data(pick_char(base));
          end else begin
            req     = ITEM_W'($urandom);
            req.cmd = CMD_UNKNOWN;
            send_request(req);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 22;
    recv_stall_pct = 55;
    test_idle_matcher();
    test_match_and_rearm();
    test_restart_and_reload();
    test_register_clamp();
    test_random_traffic(22, 55, 430);
    test_random_traffic(55, 22, 430);
    test_random_traffic(0, 0, 430);
    drain_matcher();

    $display("Sent %0d requests under %0d register writes; checked %0d results, %0d with hits.",
             requests_sent, reg_writes, results_seen, hits_seen);
    $display("Traffic ran with sender gaps and receiver stalls, each side in turn, then none.");
    if (errors == 0) begin
      $display("multi_pattern_byte_matcher test passed");
    end else begin
      $display("multi_pattern_byte_matcher test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("multi_pattern_byte_matcher test failed");
    $finish;
  end

endmodule

// ----- multi_pattern_byte_matcher.f -----
src/mpbm_pkg.sv
src/mpbm_ram.sv
src/mpbm_cell.sv
src/multi_pattern_byte_matcher.sv
dv/tb_multi_pattern_byte_matcher.sv
